// ===== sv/msrp_pkg.sv =====
// ----------------------------------------------------------------------------
// msrp_pkg
// Shared types and constants for the motor speed ramp and pwm duty block.
// ----------------------------------------------------------------------------
package msrp_pkg;

  // register indexes on the configuration channel
  localparam logic [1:0] RegInvert    = 2'd0;
  localparam logic [1:0] RegFullScale = 2'd1;
  localparam logic [1:0] RegStep      = 2'd2;
  localparam logic [1:0] RegFaultEn   = 2'd3;

  // item opcodes
  localparam logic OpSetTarget = 1'b0;
  localparam logic OpTick      = 1'b1;

  // full scale speed
  localparam logic signed [14:0] SpeedMax = 15'sd10000;

  // reset values of the configuration registers
  localparam logic [19:0] FullScaleReset = 20'd1000000;
  localparam logic [13:0] StepReset      = 14'd100;

  // divide by 10000 = shift right by 4, then multiply by 2^40/625 rounded up
  localparam int unsigned  DivShift   = 4;
  localparam logic [30:0]  RecipMagic = 31'd1759218605;
  localparam int unsigned  RecipShift = 40;

  typedef struct packed {
    logic               opcode;
    logic signed [15:0] target_speed;
    logic               fault_active;
  } in_t;

  typedef struct packed {
    logic signed [14:0] current_speed;
    logic [19:0]        duty_count;
    logic               dir_a;
    logic               dir_b;
    logic               enable_out;
  } out_t;

  typedef struct packed {
    logic        invert;
    logic [19:0] full_scale;
    logic [13:0] step;
    logic        fault_en;
  } cfg_t;

  // result of the ramp stage
  typedef struct packed {
    logic signed [14:0] speed;
    logic [13:0]        mag;
    logic               upd;
    logic               dir_a;
    logic               enable;
  } lvl_t;

  // result of the duty stages
  typedef struct packed {
    logic signed [14:0] speed;
    logic [19:0]        quo;
    logic               upd;
    logic               dir_a;
    logic               enable;
  } duty_res_t;

endpackage

// ===== sv/msrp_ramp.sv =====
// ----------------------------------------------------------------------------
// msrp_ramp
// Target and speed state, one ramp step per tick, fault latch.
// ----------------------------------------------------------------------------
module msrp_ramp (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  msrp_pkg::in_t   in_data_i,
  input  msrp_pkg::cfg_t  cfg_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output msrp_pkg::lvl_t  out_data_o
);

  logic signed [14:0] tgt_q, tgt_d;
  logic signed [14:0] cur_q, cur_d;
  logic               rev_q, rev_d;
  logic               en_q, en_d;
  logic               upd;
  logic               fire;

  logic signed [16:0] cur_x, tgt_x, step_x, next_x, gap_x;
  logic [16:0]        mag_next, mag_tgt, mag_gap;
  logic               snap;
  logic [14:0]        mag_cur;

  logic               valid_q;
  msrp_pkg::lvl_t     data_q;

  assign in_ready_o = !valid_q || out_ready_i;
  assign fire       = in_valid_i && in_ready_o;

  assign cur_x    = 17'(cur_q);
  assign tgt_x    = 17'(tgt_q);
  assign step_x   = {3'b000, cfg_i.step};
  assign next_x   = (tgt_q > cur_q) ? (cur_x + step_x) : (cur_x - step_x);
  assign gap_x    = tgt_x - next_x;
  assign mag_next = next_x[16] ? 17'(-next_x) : 17'(next_x);
  assign mag_tgt  = tgt_x[16] ? 17'(-tgt_x) : 17'(tgt_x);
  assign mag_gap  = gap_x[16] ? 17'(-gap_x) : 17'(gap_x);
  // overshoot in magnitude or less than one step left: land on target
  assign snap     = (mag_next > mag_tgt) || (mag_gap < 17'(cfg_i.step));

  always_comb begin
    tgt_d = tgt_q;
    cur_d = cur_q;
    rev_d = rev_q;
    en_d  = en_q;
    upd   = 1'b0;
    if (in_data_i.opcode == msrp_pkg::OpSetTarget) begin
      if (in_data_i.target_speed > 16'(msrp_pkg::SpeedMax)) begin
        tgt_d = msrp_pkg::SpeedMax;
      end else if (in_data_i.target_speed < -16'(msrp_pkg::SpeedMax)) begin
        tgt_d = -msrp_pkg::SpeedMax;
      end else begin
        tgt_d = in_data_i.target_speed[14:0];
      end
    end else if (cfg_i.fault_en && in_data_i.fault_active) begin
      tgt_d = '0;
      en_d  = 1'b0;
    end else if (tgt_q != cur_q) begin
      cur_d = snap ? tgt_q : next_x[14:0];
      rev_d = cur_d[14];
      upd   = 1'b1;
    end
  end

  assign mag_cur = cur_d[14] ? 15'(-cur_d) : 15'(cur_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_q   <= '0;
      cur_q   <= '0;
      rev_q   <= 1'b0;
      en_q    <= 1'b1;
      valid_q <= 1'b0;
    end else begin
      if (fire) begin
        tgt_q <= tgt_d;
        cur_q <= cur_d;
        rev_q <= rev_d;
        en_q  <= en_d;
      end
      if (in_ready_o) begin
        valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      data_q.speed  <= cur_d;
      data_q.mag    <= mag_cur[13:0];
      data_q.upd    <= upd;
      data_q.dir_a  <= rev_d ^ cfg_i.invert;
      data_q.enable <= en_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// ===== sv/msrp_duty.sv =====
// ----------------------------------------------------------------------------
// msrp_duty
// Duty scaling: |speed| * full_scale, then divide by 10000 by reciprocal.
// ----------------------------------------------------------------------------
module msrp_duty (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  msrp_pkg::lvl_t       in_data_i,
  input  logic [19:0]          full_scale_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output msrp_pkg::duty_res_t  out_data_o
);

  // product stage
  logic               s2_valid_q;
  logic               s2_ready;
  logic [33:0]        s2_prod_q;
  msrp_pkg::lvl_t     s2_lvl_q;

  // quotient stage
  logic               s3_valid_q;
  msrp_pkg::duty_res_t s3_q;

  logic [29:0]        div_in;
  logic [60:0]        recip_prod;

  assign s2_ready   = !s3_valid_q || out_ready_i;
  assign in_ready_o = !s2_valid_q || s2_ready;

  assign div_in     = s2_prod_q[33:msrp_pkg::DivShift];
  assign recip_prod = 61'(div_in) * 61'(msrp_pkg::RecipMagic);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s2_valid_q <= in_valid_i;
      end
      if (s2_ready) begin
        s3_valid_q <= s2_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s2_prod_q <= 34'(in_data_i.mag) * 34'(full_scale_i);
      s2_lvl_q  <= in_data_i;
    end
    if (s2_valid_q && s2_ready) begin
      s3_q.speed  <= s2_lvl_q.speed;
      s3_q.quo    <= recip_prod[msrp_pkg::RecipShift +: 20];
      s3_q.upd    <= s2_lvl_q.upd;
      s3_q.dir_a  <= s2_lvl_q.dir_a;
      s3_q.enable <= s2_lvl_q.enable;
    end
  end

  assign out_valid_o = s3_valid_q;
  assign out_data_o  = s3_q;

endmodule

// ===== sv/motor_speed_ramp_pwm.sv =====
// ----------------------------------------------------------------------------
// motor_speed_ramp_pwm
// Slew-rate limited motor speed with pwm duty and direction outputs.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o/in_data_i) takes set-target commands
// and loop ticks; each item gives exactly one result on the output channel
// (out_valid_o/out_ready_i/out_data_o) in the order taken.
// Configuration writes come on cfg_valid_i with cfg_index_i/cfg_data_i and
// are always taken (cfg_ready_o high); write them only while no item is
// in flight.
// A result passes through the input register, ramp stage, product stage,
// reciprocal stage and output register.
// Throughput: one item per cycle while out_ready_i stays high; the ramp
// state updates in a single stage, so back-to-back ticks see each other's
// speed, and the duty multipliers are pipelined behind it.
// Reset puts speed and target at zero, duty at zero, direction forward and
// the driver enabled, and loads the register defaults.
// When the receiver stalls the pipeline fills; in_ready_o drops only once
// all five stages hold items.
// ----------------------------------------------------------------------------
module motor_speed_ramp_pwm (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  msrp_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output msrp_pkg::out_t  out_data_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [1:0]      cfg_index_i,
  input  logic [19:0]     cfg_data_i
);

  msrp_pkg::cfg_t       cfg_q;

  logic                 s0_valid_q;
  msrp_pkg::in_t        s0_q;
  logic                 ramp_ready;

  logic                 lvl_valid;
  logic                 duty_ready;
  msrp_pkg::lvl_t       lvl;

  logic                 res_valid;
  logic                 res_ready;
  msrp_pkg::duty_res_t  res;

  logic                 out_valid_q;
  msrp_pkg::out_t       out_q;
  logic [19:0]          duty_q;
  logic [19:0]          duty_d;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.invert     <= 1'b0;
      cfg_q.full_scale <= msrp_pkg::FullScaleReset;
      cfg_q.step       <= msrp_pkg::StepReset;
      cfg_q.fault_en   <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        msrp_pkg::RegInvert:    cfg_q.invert     <= cfg_data_i[0];
        msrp_pkg::RegFullScale: cfg_q.full_scale <= cfg_data_i;
        msrp_pkg::RegStep:      cfg_q.step       <= cfg_data_i[13:0];
        msrp_pkg::RegFaultEn:   cfg_q.fault_en   <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // input register
  assign in_ready_o = !s0_valid_q || ramp_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s0_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s0_q <= in_data_i;
    end
  end

  msrp_ramp u_ramp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s0_valid_q),
    .in_ready_o  (ramp_ready),
    .in_data_i   (s0_q),
    .cfg_i       (cfg_q),
    .out_valid_o (lvl_valid),
    .out_ready_i (duty_ready),
    .out_data_o  (lvl)
  );

  msrp_duty u_duty (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (lvl_valid),
    .in_ready_o   (duty_ready),
    .in_data_i    (lvl),
    .full_scale_i (cfg_q.full_scale),
    .out_valid_o  (res_valid),
    .out_ready_i  (res_ready),
    .out_data_o   (res)
  );

  // output register; duty holds its last value unless the speed moved
  assign res_ready = !out_valid_q || out_ready_i;
  assign duty_d    = res.upd ? res.quo : duty_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      duty_q      <= '0;
    end else begin
      if (res_ready) begin
        out_valid_q <= res_valid;
      end
      if (res_valid && res_ready) begin
        duty_q <= duty_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q.current_speed <= res.speed;
      out_q.duty_count    <= duty_d;
      out_q.dir_a         <= res.dir_a;
      out_q.dir_b         <= ~res.dir_a;
      out_q.enable_out    <= res.enable;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
